// ----- src/hts_pkg.sv -----
// ----------------------------------------------------------------------------
// hts_pkg: shared constants and types of the heightmap triangle sampler
// grid geometry, fixed-point widths, reciprocal constants and the queue entry
// ----------------------------------------------------------------------------
package hts_pkg;

  // grid geometry
  localparam int CELLS        = 64;
  localparam int VERTS        = CELLS + 1;
  localparam int STORE_DEPTH  = VERTS * VERTS;
  localparam int HALF_VERTS   = (VERTS + 1) / 2;
  localparam int BANK_DEPTH   = HALF_VERTS * HALF_VERTS;
  localparam int BANK_AW      = $clog2(BANK_DEPTH);
  localparam int NUM_BANKS    = 4;

  // field widths
  localparam int IDX_W        = 13;
  localparam int HGT_W        = 16;
  localparam int POS_W        = 20;
  localparam int IN_TDATA_W   = 72;
  localparam int OUT_TDATA_W  = 16;

  // positions: cell of 12800 in Q.8, split as 50 coarse steps of 256
  localparam int CELL_Q8      = 12800;
  localparam int CELL_COARSE  = CELL_Q8 / 256;
  localparam int HALF_SPAN_Q8 = CELLS * CELL_Q8 / 2;
  localparam int POS_BIAS     = 10;
  localparam int CRS_W        = POS_W + 1 - 8;
  localparam int GRID_W       = 8;
  localparam int HV_W         = $clog2(HALF_VERTS);
  localparam int REM_W        = 6;
  localparam int WGT_W        = 14;

  // reciprocal for the small divides (by 50 and by 65), one correction step after
  localparam int RCP_SH       = 13;
  localparam int RCP_W        = 8;
  localparam int RCP_CRS      = (1 << RCP_SH) / CELL_COARSE;
  localparam int RCP_IDX      = (1 << RCP_SH) / VERTS;
  localparam int SPRD_W       = CRS_W + RCP_W;

  // interpolation datapath
  localparam int DIF_W        = HGT_W + 1;
  localparam int MUL_W        = DIF_W + WGT_W + 1;
  localparam int ACC_W        = MUL_W - 8;
  localparam int T_W          = 22;
  localparam int MAX_ACC      = (1 << HGT_W) * CELL_COARSE - 1;
  localparam int OUT_SH       = T_W;
  localparam int OUT_RCP      = (1 << OUT_SH) / CELL_COARSE;
  localparam int OUT_RCP_W    = 17;
  localparam int OPRD_W       = T_W + OUT_RCP_W;

  // item kinds on tuser
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_QUERY   = 1'b1;

  // classified item between front and back
  typedef struct packed {
    logic             is_query;
    logic             wr_ok;
    logic [IDX_W-1:0] idx;
    logic [HGT_W-1:0] hgt;
    logic [CRS_W-1:0] crs_x;
    logic [CRS_W-1:0] crs_z;
    logic [7:0]       frac_x;
    logic [7:0]       frac_z;
  } q_entry_t;

endpackage

// ----- src/hts_ram.sv -----
// ----------------------------------------------------------------------------
// hts_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module hts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1089
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/hts_front.sv -----
// ----------------------------------------------------------------------------
// hts_front: input stage
// takes items, splits the fields and maps query positions to biased grid units
// ----------------------------------------------------------------------------
module hts_front
  import hts_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic                  in_tuser,
  input  logic                  clr_busy,
  output logic                  ent_valid,
  input  logic                  ent_ready,
  output q_entry_t              ent_data
);

  logic [IDX_W-1:0]        idx;
  logic [HGT_W-1:0]        hgt;
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] pz;
  logic signed [POS_W:0]   nx;
  logic signed [POS_W:0]   nz;
  q_entry_t                ent_nxt;
  q_entry_t                ent_r;
  logic                    valid_r;

  assign idx = in_tdata[IDX_W-1:0];
  assign hgt = in_tdata[IDX_W +: HGT_W];
  assign px  = $signed(in_tdata[IDX_W+HGT_W +: POS_W]);
  assign pz  = $signed(in_tdata[IDX_W+HGT_W+POS_W +: POS_W]);

  // shift the origin to the grid corner, z runs the other way
  assign nx = $signed({px[POS_W-1], px}) + $signed((POS_W+1)'(HALF_SPAN_Q8));
  assign nz = $signed((POS_W+1)'(HALF_SPAN_Q8)) - $signed({pz[POS_W-1], pz});

  always_comb begin
    ent_nxt.is_query = (in_tuser == OP_QUERY);
    ent_nxt.wr_ok    = (idx < IDX_W'(STORE_DEPTH));
    ent_nxt.idx      = idx;
    ent_nxt.hgt      = hgt;
    ent_nxt.crs_x    = nx[POS_W:8] + CRS_W'(POS_BIAS * CELL_COARSE);
    ent_nxt.crs_z    = nz[POS_W:8] + CRS_W'(POS_BIAS * CELL_COARSE);
    ent_nxt.frac_x   = nx[7:0];
    ent_nxt.frac_z   = nz[7:0];
  end

  assign in_tready = !clr_busy && (!valid_r || ent_ready);
  assign ent_valid = valid_r;
  assign ent_data  = ent_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ----- src/hts_queue.sv -----
// ----------------------------------------------------------------------------
// hts_queue: small item queue
// decouples the input stage from the lookup pipeline
// ----------------------------------------------------------------------------
module hts_queue
  import hts_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push_valid,
  output logic     push_ready,
  input  q_entry_t push_data,
  output logic     pop_valid,
  input  logic     pop_ready,
  output q_entry_t pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push_go, pop_go;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push_go    = push_valid && push_ready;
  assign pop_go     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push_go) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_go) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CW'(push_go) - CW'(pop_go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_go) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- src/hts_back.sv -----
// ----------------------------------------------------------------------------
// hts_back: lookup and interpolation pipeline
// cell split, four banked corner reads, triangle blend, floor divide by cell
// ----------------------------------------------------------------------------
module hts_back
  import hts_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   ent_valid,
  output logic                   ent_ready,
  input  q_entry_t               ent_data,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   clr_busy
);

  typedef struct packed {
    logic [7:0] quo;
    logic [7:0] rem;
  } divres_t;

  // quotient from the reciprocal estimate, then one correction step
  function automatic divres_t fix_quot(input logic [CRS_W-1:0] num,
                                       input logic [SPRD_W-1:0] prod,
                                       input logic [7:0] dvs);
    divres_t          res;
    logic [CRS_W-1:0] mul;
    logic [CRS_W-1:0] rem;
    res.quo = prod[RCP_SH +: 8];
    mul     = CRS_W'(res.quo) * CRS_W'(dvs);
    rem     = num - mul;
    if (rem >= CRS_W'(dvs)) begin
      res.quo = res.quo + 8'd1;
      rem     = rem - CRS_W'(dvs);
    end
    res.rem = rem[7:0];
    return res;
  endfunction

  logic adv;
  logic pop_go;

  // clearing sweep
  logic               clr_busy_r, clr_busy_nxt;
  logic [BANK_AW-1:0] clr_addr_r, clr_addr_nxt;

  // stage 1: reciprocal products
  logic              v1_r;
  q_entry_t          e1_r;
  logic [SPRD_W-1:0] px1_r, pz1_r, pi1_r;
  logic [SPRD_W-1:0] px1_nxt, pz1_nxt, pi1_nxt;

  // stage 2: cell and in-cell offset
  logic                     v2_r, isq2_r, wok2_r;
  logic signed [GRID_W-1:0] row2_r, col2_r, row2_nxt, col2_nxt;
  logic [WGT_W-1:0]         rx2_r, rz2_r, rx2_nxt, rz2_nxt;
  logic [HGT_W-1:0]         whgt2_r;
  divres_t                  dx, dz, di;

  // stage 3: bank read
  logic                 v3_r, r0_3_r, c0_3_r;
  logic [NUM_BANKS-1:0] ok3_r, ok3_nxt;
  logic [WGT_W-1:0]     rx3_r, rz3_r;
  logic [BANK_AW-1:0]   bank_addr [NUM_BANKS];
  logic [HGT_W-1:0]     bank_rd   [NUM_BANKS];

  // stage 4: triangle select
  logic                    v4_r;
  logic [HGT_W-1:0]        p4_r, p4_nxt;
  logic signed [DIF_W-1:0] du4_r, dv4_r, du4_nxt, dv4_nxt;
  logic [WGT_W-1:0]        wu4_r, wv4_r, wu4_nxt, wv4_nxt;
  logic [HGT_W-1:0]        cv [NUM_BANKS];
  logic [HGT_W-1:0]        lo0, hi0, lo1, hi1, ca, cb, cc, cd;
  logic                    lower;

  // stage 5: products
  logic                    v5_r;
  logic [HGT_W-1:0]        p5_r;
  logic signed [MUL_W-1:0] pu5_r, pv5_r, pu5_nxt, pv5_nxt;

  // stage 6: accumulate in coarse units
  logic                    v6_r;
  logic signed [ACC_W-1:0] acc6_r, acc6_nxt;
  logic signed [MUL_W-1:0] num6;

  // stage 7: divide estimate
  logic              v7_r;
  logic [T_W-1:0]    t7_r, t7_nxt;
  logic [OPRD_W-1:0] p7_r, p7_nxt;

  // stage 8: output register
  logic               out_valid_r;
  logic [HGT_W-1:0]   out_data_r, out_data_nxt;
  logic [HGT_W:0]     q_est, q_fix;
  logic [T_W-1:0]     q_mul, q_rem;

  assign adv       = !out_valid_r || out_tready;
  assign ent_ready = adv && !clr_busy_r;
  assign pop_go    = ent_valid && ent_ready;

  // zero sweep over all banks after reset
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == BANK_AW'(BANK_DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  // stage 1
  assign px1_nxt = SPRD_W'(ent_data.crs_x) * SPRD_W'(RCP_CRS);
  assign pz1_nxt = SPRD_W'(ent_data.crs_z) * SPRD_W'(RCP_CRS);
  assign pi1_nxt = SPRD_W'(ent_data.idx) * SPRD_W'(RCP_IDX);

  // stage 2
  always_comb begin
    dx = fix_quot(e1_r.crs_x, px1_r, 8'(CELL_COARSE));
    dz = fix_quot(e1_r.crs_z, pz1_r, 8'(CELL_COARSE));
    di = fix_quot(e1_r.idx, pi1_r, 8'(VERTS));
    if (e1_r.is_query) begin
      row2_nxt = $signed(dz.quo - 8'(POS_BIAS));
      col2_nxt = $signed(dx.quo - 8'(POS_BIAS));
    end else begin
      row2_nxt = $signed(di.quo);
      col2_nxt = $signed(di.rem);
    end
    rx2_nxt = {dx.rem[REM_W-1:0], e1_r.frac_x};
    rz2_nxt = {dz.rem[REM_W-1:0], e1_r.frac_z};
  end

  // stage 3: banks by row and column parity, bank index {row[0], col[0]}
  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam int PR = b / 2;
    localparam int PC = b % 2;
    logic signed [GRID_W-1:0] rowp, colp;
    logic                     ok;
    logic                     wr_hit;

    assign rowp = (row2_r[0] == 1'(PR)) ? row2_r : row2_r + 8'sd1;
    assign colp = (col2_r[0] == 1'(PC)) ? col2_r : col2_r + 8'sd1;
    assign ok   = !rowp[GRID_W-1] && (rowp <= $signed(GRID_W'(CELLS)))
               && !colp[GRID_W-1] && (colp <= $signed(GRID_W'(CELLS)));
    assign bank_addr[b] = ok ? BANK_AW'(rowp[HV_W:1]) * BANK_AW'(HALF_VERTS)
                               + BANK_AW'(colp[HV_W:1]) : '0;
    assign ok3_nxt[b] = ok;
    assign wr_hit = adv && v2_r && !isq2_r && wok2_r
                 && (row2_r[0] == 1'(PR)) && (col2_r[0] == 1'(PC));

    hts_ram #(
      .WIDTH (HGT_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (clr_busy_r || wr_hit),
      .waddr (clr_busy_r ? clr_addr_r : bank_addr[b]),
      .wdata (clr_busy_r ? '0 : whgt2_r),
      .re    (adv),
      .raddr (bank_addr[b]),
      .rdata (bank_rd[b])
    );
  end

  // stage 4: map banks back to corners, pick the triangle
  always_comb begin
    for (int i = 0; i < NUM_BANKS; i++) begin
      cv[i] = ok3_r[i] ? bank_rd[i] : '0;
    end
    lo0 = c0_3_r ? cv[1] : cv[0];
    hi0 = c0_3_r ? cv[0] : cv[1];
    lo1 = c0_3_r ? cv[3] : cv[2];
    hi1 = c0_3_r ? cv[2] : cv[3];
    ca  = r0_3_r ? lo1 : lo0;
    cb  = r0_3_r ? hi1 : hi0;
    cc  = r0_3_r ? lo0 : lo1;
    cd  = r0_3_r ? hi0 : hi1;
    lower = ((WGT_W+1)'(rx3_r) + (WGT_W+1)'(rz3_r)) < (WGT_W+1)'(CELL_Q8);
    if (lower) begin
      p4_nxt  = ca;
      du4_nxt = $signed({1'b0, cb}) - $signed({1'b0, ca});
      dv4_nxt = $signed({1'b0, cc}) - $signed({1'b0, ca});
      wu4_nxt = rx3_r;
      wv4_nxt = rz3_r;
    end else begin
      p4_nxt  = cd;
      du4_nxt = $signed({1'b0, cc}) - $signed({1'b0, cd});
      dv4_nxt = $signed({1'b0, cb}) - $signed({1'b0, cd});
      wu4_nxt = WGT_W'(CELL_Q8) - rx3_r;
      wv4_nxt = WGT_W'(CELL_Q8) - rz3_r;
    end
  end

  // stage 5
  assign pu5_nxt = $signed({{(MUL_W-DIF_W){du4_r[DIF_W-1]}}, du4_r})
                 * $signed({{(MUL_W-WGT_W){1'b0}}, wu4_r});
  assign pv5_nxt = $signed({{(MUL_W-DIF_W){dv4_r[DIF_W-1]}}, dv4_r})
                 * $signed({{(MUL_W-WGT_W){1'b0}}, wv4_r});

  // stage 6: base*50 plus floor(sum/256)
  assign num6     = pu5_r + pv5_r;
  assign acc6_nxt = $signed(ACC_W'(p5_r) * ACC_W'(CELL_COARSE)) + $signed(num6[MUL_W-1:8]);

  // stage 7: clamp into the result range, reciprocal multiply
  always_comb begin
    if (acc6_r[ACC_W-1]) begin
      t7_nxt = '0;
    end else if (acc6_r > $signed(ACC_W'(MAX_ACC))) begin
      t7_nxt = T_W'(MAX_ACC);
    end else begin
      t7_nxt = acc6_r[T_W-1:0];
    end
    p7_nxt = OPRD_W'(t7_nxt) * OPRD_W'(OUT_RCP);
  end

  // stage 8: correct the quotient
  always_comb begin
    q_est = p7_r[OUT_SH +: HGT_W+1];
    q_mul = T_W'(q_est) * T_W'(CELL_COARSE);
    q_rem = t7_r - q_mul;
    q_fix = (q_rem >= T_W'(CELL_COARSE)) ? q_est + 1'b1 : q_est;
    out_data_nxt = q_fix[HGT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r  <= 1'b1;
      clr_addr_r  <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      v7_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (adv) begin
        v1_r        <= pop_go;
        v2_r        <= v1_r;
        v3_r        <= v2_r && isq2_r;
        v4_r        <= v3_r;
        v5_r        <= v4_r;
        v6_r        <= v5_r;
        v7_r        <= v6_r;
        out_valid_r <= v7_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e1_r       <= ent_data;
      px1_r      <= px1_nxt;
      pz1_r      <= pz1_nxt;
      pi1_r      <= pi1_nxt;
      isq2_r     <= e1_r.is_query;
      wok2_r     <= e1_r.wr_ok;
      whgt2_r    <= e1_r.hgt;
      row2_r     <= row2_nxt;
      col2_r     <= col2_nxt;
      rx2_r      <= rx2_nxt;
      rz2_r      <= rz2_nxt;
      r0_3_r     <= row2_r[0];
      c0_3_r     <= col2_r[0];
      ok3_r      <= ok3_nxt;
      rx3_r      <= rx2_r;
      rz3_r      <= rz2_r;
      p4_r       <= p4_nxt;
      du4_r      <= du4_nxt;
      dv4_r      <= dv4_nxt;
      wu4_r      <= wu4_nxt;
      wv4_r      <= wv4_nxt;
      p5_r       <= p4_r;
      pu5_r      <= pu5_nxt;
      pv5_r      <= pv5_nxt;
      acc6_r     <= acc6_nxt;
      t7_r       <= t7_nxt;
      p7_r       <= p7_nxt;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign clr_busy   = clr_busy_r;

endmodule

// ----- src/heightmap_triangle_sampler.sv -----
// ----------------------------------------------------------------------------
// heightmap_triangle_sampler: terrain height lookup on a 65 x 65 vertex grid
// Usage:
//   in_*  : one item per transfer; in_tuser selects write (0) or query (1).
//           a write stores one Q12.4 height at row*65+col and gives no result,
//           indexes past the grid are dropped. a query gives world x/z in Q.8.
//   out_* : one transfer per query, the interpolated Q12.4 height, floored.
//   Results come back in query order; a write is seen by every later query.
// Throughput: one item per cycle while out_tready is high, the four grid corners
//   come from four parity banks read in the same cycle.
// Path: a query passes the input register, the queue and eight pipeline stages.
// Reset: rst_n is synchronous; afterwards the grid is zeroed by a sweep over all
//   1089 addresses (one address of all four banks per cycle), in_tready stays low.
// Stall: a low out_tready with a result held freezes the lookup pipeline; a 4-entry
//   queue and the input register keep taking items until they fill, then in_tready drops.
// ----------------------------------------------------------------------------
module heightmap_triangle_sampler
  import hts_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // entry_index[12:0], entry_height[28:13],
                                             // pos_x[48:29], pos_z[68:49], zero pad
  input  logic                   in_tuser,   // op: 0 write, 1 query
  // result channel
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // height[15:0]
);

  // front to queue
  logic     f_valid;
  logic     f_ready;
  q_entry_t f_data;

  // queue to lookup pipeline
  logic     b_valid;
  logic     b_ready;
  q_entry_t b_data;

  // high while the grid is being zeroed
  logic     clr_busy;

  hts_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .clr_busy  (clr_busy),
    .ent_valid (f_valid),
    .ent_ready (f_ready),
    .ent_data  (f_data)
  );

  hts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  (f_data),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_data   (b_data)
  );

  // corner reads, triangle blend and output register
  hts_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .ent_valid  (b_valid),
    .ent_ready  (b_ready),
    .ent_data   (b_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .clr_busy   (clr_busy)
  );

endmodule
